### rtl/core/rtcmdf_pkg.sv
// ----------------------------------------------------------------------------
// rtcmdf_pkg
// Shared types, constants and the CRC-24Q byte update for the RTCM3 deframer.
// ----------------------------------------------------------------------------
package rtcmdf_pkg;

  localparam int unsigned LenW   = 11;
  localparam int unsigned CrcW   = 24;
  localparam int unsigned MaxFrame = 1029;

  localparam logic [7:0]      Preamble     = 8'hD3;
  localparam logic [7:0]      ReservedMask = 8'hFC;
  localparam logic [CrcW-1:0] CrcPoly      = 24'h864CFB;
  localparam logic [LenW-1:0] LimitReset   = LenW'(MaxFrame);
  localparam logic [LenW-1:0] HeaderTrail  = LenW'(6);
  localparam logic [LenW-1:0] MinLimit     = LenW'(3);

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_VALID     = 2'd1,
    ST_CRC_ERROR = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_WAIT   = 4'b0001,
    PH_LEN_HI = 4'b0010,
    PH_LEN_LO = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0]      frame_byte;
    logic            in_frame;
    logic [LenW-1:0] byte_position;
    status_t         status;
    logic [LenW-1:0] frame_length;
  } result_t;

  function automatic logic [CrcW-1:0] crc_add_byte(input logic [CrcW-1:0] crc,
                                                   input logic [7:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/rtcmdf_if.sv
// ----------------------------------------------------------------------------
// rtcmdf_if
// Valid/ready channels for received bytes and deframer results.
// ----------------------------------------------------------------------------
interface rtcmdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rtcmdf_out_if;
  logic                         valid;
  logic                         ready;
  logic [7:0]                   frame_byte;
  logic                         in_frame;
  logic [rtcmdf_pkg::LenW-1:0]  byte_position;
  logic [1:0]                   status;
  logic [rtcmdf_pkg::LenW-1:0]  frame_length;

  modport source (output valid, output frame_byte, output in_frame, output byte_position,
                  output status, output frame_length, input ready);
  modport sink   (input valid, input frame_byte, input in_frame, input byte_position,
                  input status, input frame_length, output ready);
endinterface

### rtl/core/rtcm3_frame_deframer_crc24q_top.sv
// ----------------------------------------------------------------------------
// rtcm3_frame_deframer_crc24q_top
// RTCM3 frame finder with on-the-fly CRC-24Q check.
// ----------------------------------------------------------------------------
// One received byte per request, one result per request. The block takes a
// byte every clock cycle while its result register is empty or being drained;
// each result appears in the cycle after its byte is accepted. The frame state
// and the eight-bit CRC-24Q update sit in combinational logic ahead of the
// result register. Write cfg_wdata with cfg_we high to set the frame limit
// (reset 1029) while the block is idle.
module rtcm3_frame_deframer_crc24q_top #(
  parameter int unsigned MaxFrame = rtcmdf_pkg::MaxFrame
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rtcmdf_pkg::LenW-1:0] cfg_wdata,
  rtcmdf_in_if.sink                   in_port,
  rtcmdf_out_if.source                out_port
);

  rtcmdf_pkg::result_t res;
  rtcmdf_pkg::result_t out_res;
  logic                can_load;
  logic                take;

  assign in_port.ready = can_load;
  assign take          = in_port.valid && can_load;

  rtcmdf_parser #(
    .MaxFrame (MaxFrame)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .data_byte (in_port.data_byte),
    .res       (res)
  );

  rtcmdf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .res       (res),
    .out_ready (out_port.ready),
    .out_valid (out_port.valid),
    .can_load  (can_load),
    .out_res   (out_res)
  );

  assign out_port.frame_byte    = out_res.frame_byte;
  assign out_port.in_frame      = out_res.in_frame;
  assign out_port.byte_position = out_res.byte_position;
  assign out_port.status        = out_res.status;
  assign out_port.frame_length  = out_res.frame_length;

endmodule

### rtl/core/rtcmdf_parser.sv
// ----------------------------------------------------------------------------
// rtcmdf_parser
// Frame state, running CRC and per-byte result, one byte per cycle while take is high.
// ----------------------------------------------------------------------------
module rtcmdf_parser #(
  parameter int unsigned MaxFrame = rtcmdf_pkg::MaxFrame
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rtcmdf_pkg::LenW-1:0] cfg_wdata,
  input  logic                        take,
  input  logic [7:0]                  data_byte,
  output rtcmdf_pkg::result_t         res
);

  localparam int unsigned LW = rtcmdf_pkg::LenW;
  localparam int unsigned CW = rtcmdf_pkg::CrcW;
  localparam logic [LW-1:0] FrameCap = LW'(MaxFrame);

  rtcmdf_pkg::phase_t phase_r, phase_nxt;
  logic [LW-1:0] limit_r;
  logic [LW-1:0] taken_r, taken_nxt;
  logic [LW-1:0] total_r, total_nxt;
  logic [CW-1:0] crc_r, crc_nxt;
  logic [CW-1:0] trail_r, trail_nxt;

  logic [LW-1:0] limit_eff;
  logic [LW-1:0] len_total;
  logic [LW-1:0] pos_inc;
  logic [CW-1:0] crc_upd;

  assign limit_eff = (limit_r < FrameCap) ? limit_r : FrameCap;
  assign len_total = {1'b0, total_r[9:8], data_byte} + rtcmdf_pkg::HeaderTrail;
  assign pos_inc   = taken_r + LW'(1);
  assign crc_upd   = rtcmdf_pkg::crc_add_byte(crc_r, data_byte);

  always_comb begin
    phase_nxt = phase_r;
    taken_nxt = taken_r;
    total_nxt = total_r;
    crc_nxt   = crc_r;
    trail_nxt = trail_r;
    res.frame_byte    = data_byte;
    res.in_frame      = 1'b0;
    res.byte_position = '0;
    res.status        = rtcmdf_pkg::ST_NONE;
    res.frame_length  = '0;
    case (phase_r)
      rtcmdf_pkg::PH_WAIT: begin
        if (data_byte == rtcmdf_pkg::Preamble) begin
          if (limit_eff < rtcmdf_pkg::MinLimit) begin
            res.status = rtcmdf_pkg::ST_TOO_LARGE;
          end else begin
            res.in_frame = 1'b1;
            crc_nxt   = rtcmdf_pkg::crc_add_byte('0, data_byte);
            trail_nxt = '0;
            taken_nxt = LW'(1);
            phase_nxt = rtcmdf_pkg::PH_LEN_HI;
          end
        end
      end
      rtcmdf_pkg::PH_LEN_HI: begin
        res.in_frame      = 1'b1;
        res.byte_position = LW'(1);
        if ((data_byte & rtcmdf_pkg::ReservedMask) != 8'h00) begin
          phase_nxt = rtcmdf_pkg::PH_WAIT;
          taken_nxt = '0;
          total_nxt = '0;
          crc_nxt   = '0;
          trail_nxt = '0;
        end else begin
          crc_nxt   = crc_upd;
          total_nxt = {1'b0, data_byte[1:0], 8'h00};
          taken_nxt = LW'(2);
          phase_nxt = rtcmdf_pkg::PH_LEN_LO;
        end
      end
      rtcmdf_pkg::PH_LEN_LO: begin
        res.in_frame      = 1'b1;
        res.byte_position = LW'(2);
        if (len_total > limit_eff) begin
          res.status = rtcmdf_pkg::ST_TOO_LARGE;
          phase_nxt = rtcmdf_pkg::PH_WAIT;
          taken_nxt = '0;
          total_nxt = '0;
          crc_nxt   = '0;
          trail_nxt = '0;
        end else begin
          crc_nxt   = crc_upd;
          total_nxt = len_total;
          taken_nxt = LW'(3);
          phase_nxt = rtcmdf_pkg::PH_BODY;
        end
      end
      rtcmdf_pkg::PH_BODY: begin
        res.in_frame      = 1'b1;
        res.byte_position = taken_r;
        if ((taken_r + LW'(3)) < total_r) begin
          crc_nxt = crc_upd;
        end else begin
          trail_nxt = {trail_r[CW-9:0], data_byte};
        end
        taken_nxt = pos_inc;
        if (pos_inc >= total_r) begin
          res.status       = (crc_r == trail_nxt) ? rtcmdf_pkg::ST_VALID
                                                  : rtcmdf_pkg::ST_CRC_ERROR;
          res.frame_length = total_r;
          phase_nxt = rtcmdf_pkg::PH_WAIT;
          taken_nxt = '0;
          total_nxt = '0;
          crc_nxt   = '0;
          trail_nxt = '0;
        end
      end
      default: begin
        phase_nxt = rtcmdf_pkg::PH_WAIT;
        taken_nxt = '0;
        total_nxt = '0;
        crc_nxt   = '0;
        trail_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rtcmdf_pkg::PH_WAIT;
      limit_r <= rtcmdf_pkg::LimitReset;
      taken_r <= '0;
      total_r <= '0;
      crc_r   <= '0;
      trail_r <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (take) begin
        phase_r <= phase_nxt;
        taken_r <= taken_nxt;
        total_r <= total_nxt;
        crc_r   <= crc_nxt;
        trail_r <= trail_nxt;
      end
    end
  end

endmodule

### rtl/core/rtcmdf_out_stage.sv
// ----------------------------------------------------------------------------
// rtcmdf_out_stage
// Result register; takes a new result whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module rtcmdf_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  rtcmdf_pkg::result_t res,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                can_load,
  output rtcmdf_pkg::result_t out_res
);

  logic                valid_r;
  rtcmdf_pkg::result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

### rtl/core/rtcmdf_checker.sv
// ----------------------------------------------------------------------------
// rtcmdf_checker
// Port-level checks for the RTCM3 deframer, bound to the top level.
// ----------------------------------------------------------------------------
module rtcmdf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [7:0]                  frame_byte,
  input logic                        in_frame,
  input logic [rtcmdf_pkg::LenW-1:0] byte_position,
  input logic [1:0]                  status,
  input logic [rtcmdf_pkg::LenW-1:0] frame_length
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(status))
    else $error("result changed while stalled");

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request did not produce a result");

  a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == rtcmdf_pkg::ST_VALID || status == rtcmdf_pkg::ST_CRC_ERROR)
      |-> in_frame && frame_length >= rtcmdf_pkg::HeaderTrail &&
          byte_position == frame_length - rtcmdf_pkg::LenW'(1))
    else $error("frame end with bad length or position");

  a_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == rtcmdf_pkg::ST_NONE || status == rtcmdf_pkg::ST_TOO_LARGE)
      |-> frame_length == '0)
    else $error("frame length reported without frame end");

  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_frame |-> byte_position == '0)
    else $error("position reported outside a frame");

endmodule

bind rtcm3_frame_deframer_crc24q_top rtcmdf_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_port.valid),
  .in_ready      (in_port.ready),
  .out_valid     (out_port.valid),
  .out_ready     (out_port.ready),
  .frame_byte    (out_port.frame_byte),
  .in_frame      (out_port.in_frame),
  .byte_position (out_port.byte_position),
  .status        (out_port.status),
  .frame_length  (out_port.frame_length)
);
